/* hw/rtl/irot_pkg.sv */
// shared types and constants of the 90 degree image rotator
package irot_pkg;

	// fixed field widths
	localparam int PIX_W     = 24;
	localparam int DIM_REG_W = 7;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;

	// parameter defaults
	localparam int DEF_MAX_DIM    = 64;
	localparam int DEF_PIXEL_BITS = 24;

	// register reset values
	localparam logic [DIM_REG_W-1:0] SRC_WIDTH_RST  = 7'd64;
	localparam logic [DIM_REG_W-1:0] SRC_HEIGHT_RST = 7'd64;

	// register index, taken from paddr[2]
	localparam logic REG_SRC_WIDTH  = 1'b0;
	localparam logic REG_SRC_HEIGHT = 1'b1;

	// command codes on func
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	// geometry registers as seen by the datapath
	typedef struct packed {
		logic [DIM_REG_W-1:0] src_width;
		logic [DIM_REG_W-1:0] src_height;
	} geom_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic fetch;
		logic read;
	} cmd_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SHOW = 3'b100
	} state_t;

endpackage

/* hw/rtl/image_rotate_90_clockwise_top.sv */
// 90 degree clockwise frame rotator, top level
//
// Commands are taken when start is high and busy is low. A load (func 0)
// writes one source pixel in raster order and leaves busy low; the next
// command can follow in the next cycle. A fetch (func 1) runs through states
// idle, read and show: the accept cycle computes the store address from the
// readout counters, read reads the pixel store through its registered read
// port, and show presents rotated_pixel and frame_last with done high. done
// is a one cycle strobe and cannot be held off, so the receiver must take the
// result in that cycle. The pixel store is not cleared at reset; only loaded
// entries may be fetched. Geometry registers must be written through the apb
// port only while no fetch is in flight; the block does not enforce this.
module image_rotate_90_clockwise_top #(
	parameter int MAX_DIM    = irot_pkg::DEF_MAX_DIM,
	parameter int PIXEL_BITS = irot_pkg::DEF_PIXEL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [irot_pkg::PIX_W-1:0]    pixel_in,
	output logic                          done,
	output logic [irot_pkg::PIX_W-1:0]    rotated_pixel,
	output logic                          frame_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [irot_pkg::PADDR_W-1:0]  paddr,
	input  logic [irot_pkg::PDATA_W-1:0]  pwdata,
	output logic [irot_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import irot_pkg::*;

	geom_t geom;
	cmd_t  cmd;

	// configuration registers
	irot_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	// controller
	irot_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// datapath
	irot_dp #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.geom          (geom),
		.cmd           (cmd),
		.pixel_in      (pixel_in),
		.rotated_pixel (rotated_pixel),
		.frame_last    (frame_last)
	);

endmodule

/* hw/rtl/irot_regs.sv */
// apb configuration registers: source width and height
module irot_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [irot_pkg::PADDR_W-1:0]  paddr,
	input  logic [irot_pkg::PDATA_W-1:0]  pwdata,
	output logic [irot_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output irot_pkg::geom_t               geom
);
	import irot_pkg::*;

	logic [DIM_REG_W-1:0] src_width_q;
	logic [DIM_REG_W-1:0] src_height_q;
	logic                 wr_en;

	// no wait states
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_SRC_WIDTH:  src_width_q  <= pwdata[DIM_REG_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (paddr[2])
			REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_q);
			default:        prdata = '0;
		endcase
	end

	assign geom.src_width  = src_width_q;
	assign geom.src_height = src_height_q;

endmodule

/* hw/rtl/irot_dp.sv */
// datapath: pixel store, load index, readout counters and address generation
module irot_dp #(
	parameter int MAX_DIM    = irot_pkg::DEF_MAX_DIM,
	parameter int PIXEL_BITS = irot_pkg::DEF_PIXEL_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  irot_pkg::geom_t           geom,
	input  irot_pkg::cmd_t            cmd,
	input  logic [irot_pkg::PIX_W-1:0] pixel_in,
	output logic [irot_pkg::PIX_W-1:0] rotated_pixel,
	output logic                      frame_last
);
	import irot_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOT_W  = $clog2(DEPTH + 1);

	// clamp a register value to 1..MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 == 32'd0)
			return DIM_W'(1);
		else if (v32 > 32'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		else
			return DIM_W'(v32);
	endfunction

	logic [PIXEL_BITS-1:0] mem [DEPTH];

	logic [ADDR_W-1:0]     load_index_q;
	logic [CNT_W-1:0]      out_row_q;
	logic [CNT_W-1:0]      out_col_q;
	logic [ADDR_W-1:0]     addr_s1;
	logic                  last_s1;
	logic [PIXEL_BITS-1:0] pix_s2;
	logic                  last_s2;

	logic [DIM_W-1:0]      w;
	logic [DIM_W-1:0]      h;
	logic [TOT_W-1:0]      total;
	logic [ADDR_W-1:0]     li_cur;
	logic [TOT_W-1:0]      li_inc;
	logic [ADDR_W-1:0]     li_nxt;
	logic [DIM_W-1:0]      row_cur;
	logic [DIM_W-1:0]      col_cur;
	logic [DIM_W-1:0]      col_rev;
	logic [DIM_W-1:0]      row_inc;
	logic [DIM_W-1:0]      col_inc;
	logic [CNT_W-1:0]      row_nxt;
	logic [CNT_W-1:0]      col_nxt;
	logic [TOT_W-1:0]      rd_addr;
	logic                  rd_last;

	// effective geometry
	assign w     = eff_dim(geom.src_width);
	assign h     = eff_dim(geom.src_height);
	assign total = TOT_W'(TOT_W'(w) * TOT_W'(h));

	// load index, restarted when it lies beyond the frame
	assign li_cur = (TOT_W'(load_index_q) >= total) ? '0 : load_index_q;
	assign li_inc = TOT_W'(li_cur) + TOT_W'(1);
	assign li_nxt = (li_inc >= total) ? '0 : li_inc[ADDR_W-1:0];

	// readout position, restarted when beyond the rotated frame
	assign row_cur = (DIM_W'(out_row_q) >= w) ? '0 : DIM_W'(out_row_q);
	assign col_cur = (DIM_W'(out_col_q) >= h) ? '0 : DIM_W'(out_col_q);
	assign col_rev = h - DIM_W'(1) - col_cur;
	assign rd_addr = TOT_W'(row_cur) + TOT_W'(TOT_W'(col_rev) * TOT_W'(w));
	assign rd_last = (row_cur == w - DIM_W'(1)) && (col_cur == h - DIM_W'(1));

	// column steps first, row steps at the end of each output row
	assign col_inc = col_cur + DIM_W'(1);
	assign row_inc = row_cur + DIM_W'(1);
	always_comb begin
		if (col_inc >= h) begin
			col_nxt = '0;
			row_nxt = (row_inc >= w) ? '0 : row_inc[CNT_W-1:0];
		end else begin
			col_nxt = col_inc[CNT_W-1:0];
			row_nxt = row_cur[CNT_W-1:0];
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_index_q <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
		end else begin
			if (cmd.load)
				load_index_q <= li_nxt;
			if (cmd.fetch) begin
				out_row_q <= row_nxt;
				out_col_q <= col_nxt;
			end
		end
	end

	// read address stage
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			addr_s1 <= rd_addr[ADDR_W-1:0];
			last_s1 <= rd_last;
		end
	end

	// pixel store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load)
			mem[li_cur] <= PIXEL_BITS'(pixel_in);
		if (cmd.read) begin
			pix_s2  <= mem[addr_s1];
			last_s2 <= last_s1;
		end
	end

	assign rotated_pixel = PIX_W'(pix_s2);
	assign frame_last    = last_s2;

endmodule

/* hw/rtl/irot_ctrl.sv */
// controller: command acceptance and fetch sequencing
module irot_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            func,
	output logic            busy,
	output logic            done,
	output irot_pkg::cmd_t  cmd
);
	import irot_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && !busy;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && func == FUNC_FETCH) state_d = ST_READ;
			ST_READ: state_d = ST_SHOW;
			ST_SHOW: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// commands and status
	assign busy      = (state_q != ST_IDLE);
	assign done      = (state_q == ST_SHOW);
	assign cmd.load  = accept && (func == FUNC_LOAD);
	assign cmd.fetch = accept && (func == FUNC_FETCH);
	assign cmd.read  = (state_q == ST_READ);

	// a fetch transfer gives its result strobe after the read state
	a_fetch_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> ##1 done)
		else $error("fetch without result");

	// a load transfer leaves the block free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !busy && !done)
		else $error("load stalled the block");

	// memory read only follows an accepted fetch
	a_read_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> $past(cmd.fetch))
		else $error("read without fetch");

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

/* tb/rotate_check.sv */
// rotator check: predicts each rotated pixel and compares every result transfer
module rotate_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          func,
	input  logic [irot_pkg::PIX_W-1:0]    pixel_in,
	input  logic                          done,
	input  logic [irot_pkg::PIX_W-1:0]    rotated_pixel,
	input  logic                          frame_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [irot_pkg::PADDR_W-1:0]  paddr,
	input  logic [irot_pkg::PDATA_W-1:0]  pwdata,
	input  logic                          pready,
	output int                            pending_cnt,
	output int                            error_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	import irot_pkg::*;

	localparam int DIM_MAX = DEF_MAX_DIM;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} rot_out_t;

	// own copy of the source frame, geometry and counters
	logic [PIX_W-1:0]     src_pixels [0:DIM_MAX*DIM_MAX-1];
	logic [DIM_REG_W-1:0] width_reg;
	logic [DIM_REG_W-1:0] height_reg;
	int                   load_pos;
	int                   out_row;
	int                   out_col;
	rot_out_t             rotated_due [$];

	// register value as used by the datapath: zero acts as one, large values saturate
	function automatic int dim_of(logic [DIM_REG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_MAX)
			return DIM_MAX;
		return int'(v);
	endfunction

	initial begin
		pending_cnt = 0;
		error_cnt   = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		int       w;
		int       h;
		int       total;
		int       addr;
		rot_out_t got;
		rot_out_t want;
		if (!arst_n) begin
			width_reg  = SRC_WIDTH_RST;
			height_reg = SRC_HEIGHT_RST;
			load_pos   = 0;
			out_row    = 0;
			out_col    = 0;
			rotated_due.delete();
		end else begin
			// result transfer against the oldest expected pixel
			if (done) begin
				got.pixel = rotated_pixel;
				got.last  = frame_last;
				if (rotated_due.size() == 0) begin
					$display("%0t: unexpected transfer, expected none got pixel %06h last %0b",
						$time, got.pixel, got.last);
					error_cnt++;
				end else begin
					want = rotated_due.pop_front();
					if (got.pixel !== want.pixel) begin
						$display("%0t: rotated_pixel expected %06h got %06h",
							$time, want.pixel, got.pixel);
						error_cnt++;
					end
					if (got.last !== want.last) begin
						$display("%0t: frame_last expected %0b got %0b",
							$time, want.last, got.last);
						error_cnt++;
					end
				end
			end

			// geometry register write
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SRC_WIDTH)
					width_reg = pwdata[DIM_REG_W-1:0];
				else
					height_reg = pwdata[DIM_REG_W-1:0];
			end

			// command transfer
			if (start && !busy) begin
				w     = dim_of(width_reg);
				h     = dim_of(height_reg);
				total = w * h;
				if (func == FUNC_LOAD) begin
					// raster load, index restarts when it falls outside the frame
					if (load_pos >= total)
						load_pos = 0;
					src_pixels[load_pos] = pixel_in;
					load_pos++;
					if (load_pos >= total)
						load_pos = 0;
				end else begin
					// rotated image is h wide and w tall
					if (out_row >= w)
						out_row = 0;
					if (out_col >= h)
						out_col = 0;
					addr       = out_row + (h - 1 - out_col) * w;
					want.pixel = src_pixels[addr];
					want.last  = (out_row == w - 1) && (out_col == h - 1);
					rotated_due.push_back(want);
					out_col++;
					if (out_col >= h) begin
						out_col = 0;
						out_row++;
						if (out_row >= w)
							out_row = 0;
					end
				end
			end
		end
		pending_cnt = rotated_due.size();
	end

endmodule

/* tb/testbench.sv */
// testbench top: clock, reset, command and register stimulus, and the verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import irot_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int ITEM_TARGET = 1450;
	localparam int QUIET_FROM  = 1300;

	localparam logic [PADDR_W-1:0] ADDR_SRC_WIDTH  = {REG_SRC_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_SRC_HEIGHT = {REG_SRC_HEIGHT, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               func;
	logic [PIX_W-1:0]   pixel_in;
	logic               done;
	logic [PIX_W-1:0]   rotated_pixel;
	logic               frame_last;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int pending_cnt;
	int error_cnt;
	int items_sent;
	bit idle_on;
	int cur_w;
	int cur_h;

	image_rotate_90_clockwise_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.pixel_in      (pixel_in),
		.done          (done),
		.rotated_pixel (rotated_pixel),
		.frame_last    (frame_last),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	rotate_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.pixel_in      (pixel_in),
		.done          (done),
		.rotated_pixel (rotated_pixel),
		.frame_last    (frame_last),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.pending_cnt   (pending_cnt),
		.error_cnt     (error_cnt)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// frame dimension the block will use for a register value
	function automatic int clamp_dim(logic [DIM_REG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DEF_MAX_DIM)
			return DEF_MAX_DIM;
		return int'(v);
	endfunction

	// register word for a dimension, using the aliases for 1 and 64 and junk upper bits
	function automatic logic [PDATA_W-1:0] dim_code(int dim);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		if (dim == 1)
			word[DIM_REG_W-1:0] = DIM_REG_W'($urandom_range(0, 1));
		else if (dim == DEF_MAX_DIM)
			word[DIM_REG_W-1:0] = DIM_REG_W'($urandom_range(0, 1) ? DEF_MAX_DIM :
				$urandom_range(65, 127));
		else
			word[DIM_REG_W-1:0] = DIM_REG_W'(dim);
		return word;
	endfunction

	// sender gap, start low
	task automatic hold_off(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// one command transfer, start left high for a following command
	task automatic send_cmd(logic f, logic [PIX_W-1:0] pix);
		start    <= 1'b1;
		func     <= f;
		pixel_in <= pix;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		items_sent++;
		if (idle_on && items_sent < QUIET_FROM && $urandom_range(0, 7) == 0)
			hold_off($urandom_range(1, 16));
	endtask

	// wait until every fetched pixel has come back
	task automatic drain();
		start <= 1'b0;
		while (pending_cnt != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// apb write: setup cycle, access cycle, then an idle phase with psel low
	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_geometry(logic [PDATA_W-1:0] wv, logic [PDATA_W-1:0] hv);
		drain();
		write_reg(ADDR_SRC_WIDTH, wv);
		write_reg(ADDR_SRC_HEIGHT, hv);
		cur_w = clamp_dim(wv[DIM_REG_W-1:0]);
		cur_h = clamp_dim(hv[DIM_REG_W-1:0]);
	endtask

	// a full frame of loads covers every entry the readout can touch
	task automatic load_frame();
		repeat (cur_w * cur_h)
			if (items_sent < ITEM_TARGET)
				send_cmd(FUNC_LOAD, PIX_W'($urandom()));
	endtask

	task automatic fetch_frame();
		repeat (cur_w * cur_h)
			if (items_sent < ITEM_TARGET)
				send_cmd(FUNC_FETCH, PIX_W'($urandom()));
	endtask

	// stimulus
	initial begin
		int w;
		int h;
		int mode;
		arst_n     = 1'b0;
		start      = 1'b0;
		func       = FUNC_LOAD;
		pixel_in   = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		items_sent = 0;
		idle_on    = 1'b0;
		cur_w      = DEF_MAX_DIM;
		cur_h      = DEF_MAX_DIM;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 3 wide, 2 tall source with extreme pixel values, then full readout
		set_geometry(32'd3, 32'd2);
		send_cmd(FUNC_LOAD, 24'h000000);
		send_cmd(FUNC_LOAD, 24'hFFFFFF);
		send_cmd(FUNC_LOAD, 24'h800000);
		send_cmd(FUNC_LOAD, 24'h000001);
		send_cmd(FUNC_LOAD, 24'h555555);
		send_cmd(FUNC_LOAD, 24'hAAAAAA);
		fetch_frame();

		// readout wraps into a new frame; loads leave the index mid-frame
		send_cmd(FUNC_FETCH, 24'hFFFFFF);
		send_cmd(FUNC_FETCH, 24'h000000);
		send_cmd(FUNC_LOAD, 24'h0F0F0F);
		send_cmd(FUNC_LOAD, 24'hF0F0F0);
		send_cmd(FUNC_LOAD, 24'h3C3C3C);

		// zero width acts as one; load index and readout row fall outside and restart
		set_geometry(32'hFFFF_FF80, 32'd2);
		send_cmd(FUNC_LOAD, 24'h123456);
		send_cmd(FUNC_LOAD, 24'hEDCBA9);
		repeat (3) send_cmd(FUNC_FETCH, 24'h000000);

		// random phases of new geometry, a full load, then frames and mixed traffic
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: begin
					w = DEF_MAX_DIM;
					h = $urandom_range(1, 2);
				end
				1: begin
					w = $urandom_range(1, 2);
					h = DEF_MAX_DIM;
				end
				2: begin
					w = $urandom_range(1, 16);
					h = $urandom_range(1, 16);
				end
				default: begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 8);
				end
			endcase
			idle_on = ($urandom_range(0, 2) != 0);
			set_geometry(dim_code(w), dim_code(h));
			load_frame();
			repeat ($urandom_range(1, 4)) begin
				mode = $urandom_range(0, 9);
				if (mode < 5)
					fetch_frame();
				else if (mode < 8)
					load_frame();
				else
					repeat ($urandom_range(1, 2 * cur_w * cur_h))
						if (items_sent < ITEM_TARGET)
							send_cmd(1'($urandom_range(0, 1)), PIX_W'($urandom()));
			end
		end

		// wind down and give the verdict
		idle_on = 1'b0;
		start <= 1'b0;
		while (pending_cnt != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (error_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/irot_pkg.sv
hw/rtl/irot_regs.sv
hw/rtl/irot_dp.sv
hw/rtl/irot_ctrl.sv
hw/rtl/image_rotate_90_clockwise_top.sv
tb/rotate_check.sv
tb/testbench.sv
